FILE: sv/motor_run_overcurrent_timeout_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MOTOR_RUN_OVERCURRENT_TIMEOUT_CORE_ASSERT_SVH
`define MOTOR_RUN_OVERCURRENT_TIMEOUT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MROC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MROC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mroc_pkg.sv
package mroc_pkg;

    localparam int TICK_WIDTH  = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int CMP_WIDTH   = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;
    localparam int QUAL_WIDTH  = 5;
    localparam int ADDR_WIDTH  = 4;
    localparam int TDATA_WIDTH = 8;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [CMP_WIDTH-1:0]  cmp_t;
    typedef logic [CFG_WIDTH-1:0]  cfg_word_t;
    typedef logic [QUAL_WIDTH-1:0] qual_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_RUN    = 2'd2,
        PH_QUAL   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FIN_NONE        = 2'd0,
        FIN_OVERCURRENT = 2'd1,
        FIN_TIMEOUT     = 2'd2
    } finish_t;

    typedef enum logic [1:0] {
        REG_SETTLE_TICKS      = 2'd0,
        REG_TIMEOUT_TICKS     = 2'd1,
        REG_QUALIFY_SAMPLES   = 2'd2,
        REG_QUALIFY_THRESHOLD = 2'd3
    } reg_idx_t;

    localparam logic [1:0] BRIDGE_OFF   = 2'b00;
    localparam logic [1:0] BRIDGE_CLOSE = 2'b01;
    localparam logic [1:0] BRIDGE_OPEN  = 2'b10;

    localparam cfg_word_t SETTLE_RESET    = 32'd30000;
    localparam cfg_word_t TIMEOUT_RESET   = 32'd400000;
    localparam qual_t     QSAMPLES_RESET  = 5'd20;
    localparam qual_t     QTHRESH_RESET   = 5'd15;

    typedef struct packed {
        cfg_word_t settle_ticks;
        cfg_word_t timeout_ticks;
        qual_t     qualify_samples;
        qual_t     qualify_threshold;
    } cfg_t;

    typedef struct packed {
        logic mode;
        logic open_dir;
        logic high_strength;
        logic overcurrent_line;
    } item_t;

    typedef struct packed {
        finish_t finish;
        phase_t  phase;
        logic    current_select;
        logic    driver_enable;
        logic    drive_in2;
        logic    drive_in1;
    } result_t;

endpackage

FILE: sv/mroc_engine.sv
module mroc_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  mroc_pkg::item_t item,
    input  mroc_pkg::cfg_t  cfg,
    output mroc_pkg::result_t result
);

    mroc_pkg::phase_t phase_reg;
    mroc_pkg::phase_t phase_next;
    logic [1:0]       pins_reg;
    logic [1:0]       pins_next;
    logic             enable_reg;
    logic             enable_next;
    logic             current_reg;
    logic             current_next;
    mroc_pkg::tick_t  tick_reg;
    mroc_pkg::tick_t  tick_next;
    mroc_pkg::qual_t  sample_reg;
    mroc_pkg::qual_t  sample_next;
    mroc_pkg::qual_t  low_reg;
    mroc_pkg::qual_t  low_next;
    mroc_pkg::finish_t finish;

    mroc_pkg::tick_t  tick_inc;
    mroc_pkg::qual_t  sample_inc;
    mroc_pkg::qual_t  low_inc;
    logic             line_low;
    logic             settle_done;
    logic             timed_out;
    logic             window_done;
    logic             confirmed;

    // The tick counter saturates at its largest value.
    assign tick_inc    = (tick_reg == '1) ? tick_reg : tick_reg + mroc_pkg::tick_t'(1);
    assign sample_inc  = sample_reg + mroc_pkg::qual_t'(1);
    assign line_low    = !item.overcurrent_line;
    assign low_inc     = low_reg + mroc_pkg::qual_t'(line_low);
    assign settle_done = mroc_pkg::cmp_t'(tick_inc) >= mroc_pkg::cmp_t'(cfg.settle_ticks);
    assign timed_out   = mroc_pkg::cmp_t'(tick_inc) > mroc_pkg::cmp_t'(cfg.timeout_ticks);
    assign window_done = sample_inc >= cfg.qualify_samples;
    assign confirmed   = low_inc >= cfg.qualify_threshold;

    always_comb
    begin
        phase_next = phase_reg;
        if (item.mode)
        begin
            phase_next = mroc_pkg::PH_SETTLE;
        end
        else
        begin
            unique case (phase_reg)
                mroc_pkg::PH_IDLE:
                begin
                    phase_next = mroc_pkg::PH_IDLE;
                end
                mroc_pkg::PH_SETTLE:
                begin
                    if (settle_done)
                    begin
                        phase_next = mroc_pkg::PH_RUN;
                    end
                end
                mroc_pkg::PH_RUN:
                begin
                    if (timed_out)
                    begin
                        phase_next = mroc_pkg::PH_IDLE;
                    end
                    else if (line_low)
                    begin
                        phase_next = mroc_pkg::PH_QUAL;
                    end
                end
                mroc_pkg::PH_QUAL:
                begin
                    if (window_done)
                    begin
                        phase_next = confirmed ? mroc_pkg::PH_IDLE : mroc_pkg::PH_RUN;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        pins_next    = pins_reg;
        enable_next  = enable_reg;
        current_next = current_reg;
        tick_next    = tick_reg;
        sample_next  = sample_reg;
        low_next     = low_reg;
        finish       = mroc_pkg::FIN_NONE;
        if (item.mode)
        begin
            pins_next    = item.open_dir ? mroc_pkg::BRIDGE_OPEN : mroc_pkg::BRIDGE_CLOSE;
            enable_next  = 1'b1;
            current_next = item.high_strength;
            tick_next    = '0;
            sample_next  = '0;
            low_next     = '0;
        end
        else
        begin
            unique case (phase_reg)
                mroc_pkg::PH_IDLE:
                begin
                    tick_next = tick_reg;
                end
                mroc_pkg::PH_SETTLE:
                begin
                    tick_next = settle_done ? '0 : tick_inc;
                end
                mroc_pkg::PH_RUN:
                begin
                    tick_next = tick_inc;
                    if (timed_out)
                    begin
                        pins_next   = mroc_pkg::BRIDGE_OFF;
                        enable_next = 1'b0;
                        finish      = mroc_pkg::FIN_TIMEOUT;
                    end
                    else if (line_low)
                    begin
                        sample_next = '0;
                        low_next    = '0;
                    end
                end
                mroc_pkg::PH_QUAL:
                begin
                    tick_next = tick_inc;
                    if (window_done)
                    begin
                        sample_next = '0;
                        low_next    = '0;
                        if (confirmed)
                        begin
                            pins_next   = mroc_pkg::BRIDGE_OFF;
                            enable_next = 1'b0;
                            finish      = mroc_pkg::FIN_OVERCURRENT;
                        end
                    end
                    else
                    begin
                        sample_next = sample_inc;
                        low_next    = low_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mroc_pkg::PH_IDLE;
            pins_reg    <= mroc_pkg::BRIDGE_OFF;
            enable_reg  <= 1'b0;
            current_reg <= 1'b0;
            tick_reg    <= '0;
            sample_reg  <= '0;
            low_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pins_reg    <= pins_next;
            enable_reg  <= enable_next;
            current_reg <= current_next;
            tick_reg    <= tick_next;
            sample_reg  <= sample_next;
            low_reg     <= low_next;
        end
    end

    always_comb
    begin
        result.drive_in1      = pins_next[0];
        result.drive_in2      = pins_next[1];
        result.driver_enable  = enable_next;
        result.current_select = current_next;
        result.phase          = phase_next;
        result.finish         = finish;
    end

endmodule

FILE: sv/motor_run_overcurrent_timeout_core.sv
// Accepted transactions go to the input register; their results go to the output register.
// One transaction per cycle unless stalled; the state update is one compare-and-count pass.
// The input ready drops only while the output register holds a result that is not taken.
// Reset (rst_n low, asynchronous) clears the motor state to idle with the driver disabled,
// empties both pipeline registers and loads the register defaults.
module motor_run_overcurrent_timeout_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] open_dir, [1] high_strength, [2] overcurrent_line, [7:3] zero
    input  logic [mroc_pkg::TDATA_WIDTH-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] drive_in1, [1] drive_in2, [2] driver_enable, [3] current_select,
    // [5:4] phase, [7:6] finish
    output logic [mroc_pkg::TDATA_WIDTH-1:0]  m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mroc_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [mroc_pkg::CFG_WIDTH-1:0]    pwdata,
    output logic [mroc_pkg::CFG_WIDTH-1:0]    prdata,
    output logic                              pready
);

    mroc_pkg::cfg_t    cfg_reg;
    mroc_pkg::reg_idx_t reg_idx;
    logic              cfg_write;

    logic              in_valid_reg;
    mroc_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    mroc_pkg::result_t out_data_reg;
    logic              advance;
    logic              step;
    mroc_pkg::result_t result;

    assign pready    = 1'b1;
    assign reg_idx   = mroc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks      <= mroc_pkg::SETTLE_RESET;
            cfg_reg.timeout_ticks     <= mroc_pkg::TIMEOUT_RESET;
            cfg_reg.qualify_samples   <= mroc_pkg::QSAMPLES_RESET;
            cfg_reg.qualify_threshold <= mroc_pkg::QTHRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                mroc_pkg::REG_SETTLE_TICKS:
                begin
                    cfg_reg.settle_ticks <= pwdata;
                end
                mroc_pkg::REG_TIMEOUT_TICKS:
                begin
                    cfg_reg.timeout_ticks <= pwdata;
                end
                mroc_pkg::REG_QUALIFY_SAMPLES:
                begin
                    cfg_reg.qualify_samples <= pwdata[mroc_pkg::QUAL_WIDTH-1:0];
                end
                mroc_pkg::REG_QUALIFY_THRESHOLD:
                begin
                    cfg_reg.qualify_threshold <= pwdata[mroc_pkg::QUAL_WIDTH-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mroc_pkg::REG_SETTLE_TICKS:
            begin
                prdata = cfg_reg.settle_ticks;
            end
            mroc_pkg::REG_TIMEOUT_TICKS:
            begin
                prdata = cfg_reg.timeout_ticks;
            end
            mroc_pkg::REG_QUALIFY_SAMPLES:
            begin
                prdata = mroc_pkg::CFG_WIDTH'(cfg_reg.qualify_samples);
            end
            mroc_pkg::REG_QUALIFY_THRESHOLD:
            begin
                prdata = mroc_pkg::CFG_WIDTH'(cfg_reg.qualify_threshold);
            end
        endcase
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.mode             <= s_axis_tuser;
            in_item_reg.open_dir         <= s_axis_tdata[0];
            in_item_reg.high_strength    <= s_axis_tdata[1];
            in_item_reg.overcurrent_line <= s_axis_tdata[2];
        end
    end

    mroc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: sv/mroc_checker.sv
`include "motor_run_overcurrent_timeout_core_assert.svh"

module mroc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mroc_pkg::TDATA_WIDTH-1:0] m_axis_tdata
);

    // A stalled result keeps its data until it is taken.
    `MROC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The input side is never stalled while the output side takes results.
    `MROC_ASSERT_SAME(a_ready_flow, m_axis_tready, s_axis_tready, "input stalled while output flows")

    // A stop transaction reports the motor idle, disabled and with both bridge inputs low.
    `MROC_ASSERT_SAME(a_stop_state, m_axis_tvalid && (m_axis_tdata[7:6] != 2'b00), m_axis_tdata[5:0] == {2'b00, m_axis_tdata[3], 3'b000}, "stop transaction leaves the motor driven")

    // The driver is enabled exactly while a move is active, and then one bridge input is high.
    `MROC_ASSERT_SAME(a_drive_consistent, m_axis_tvalid, (m_axis_tdata[2] == (m_axis_tdata[5:4] != 2'b00)) && ((m_axis_tdata[0] ^ m_axis_tdata[1]) == m_axis_tdata[2]), "drive pins disagree with phase")

endmodule

bind motor_run_overcurrent_timeout_core mroc_checker u_mroc_checker (.*);
